### src/afs_pkg.sv
// shared types, constants and helper functions of the aspect-fill scaler
package afs_pkg;

  // field and datapath widths
  localparam int DIM_W      = 13;
  localparam int COL_W      = 8;
  localparam int CRD_W      = 12;
  localparam int IDX_W      = 16;
  localparam int PIX_W      = 4 * COL_W;
  localparam int SCL_W      = 26;
  localparam int SUM_W      = SCL_W + 1;
  localparam int NUM_W      = SUM_W + DIM_W;
  localparam int Q_W        = DIM_W;
  localparam int DIV_LAT    = Q_W + 1;
  localparam int GN_W       = SCL_W + 2;
  localparam int GD_W       = DIM_W + 1;
  localparam int GC_W       = $clog2(GN_W);
  localparam int LIN_W      = 2 * DIM_W;
  localparam int BL_W       = 2 * COL_W;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  // queue depth, kept a power of two so the pointers wrap on their own
  localparam int FIFO_DEPTH = 4;

  // defaults of the top level parameters
  localparam int DEF_SOURCE_PIXELS = 65536;
  localparam int DEF_MAX_DIM       = 4096;

  // register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_BACK_RED   = 3'd4,
    REG_BACK_GREEN = 3'd5,
    REG_BACK_BLUE  = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd256;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd256;
  localparam logic [DIM_W-1:0] RST_DST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RST_DST_HEIGHT = 13'd480;
  localparam logic [COL_W-1:0] RST_BACK_RED   = 8'd20;
  localparam logic [COL_W-1:0] RST_BACK_GREEN = 8'd24;
  localparam logic [COL_W-1:0] RST_BACK_BLUE  = 8'd34;
  localparam logic [COL_W-1:0] ALPHA_OPAQUE   = 8'd255;

  // request function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_RENDER = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] src_index;
    logic [COL_W-1:0] pix_red;
    logic [COL_W-1:0] pix_green;
    logic [COL_W-1:0] pix_blue;
    logic [COL_W-1:0] pix_alpha;
    logic [CRD_W-1:0] dst_x;
    logic [CRD_W-1:0] dst_y;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] out_red;
    logic [COL_W-1:0] out_green;
    logic [COL_W-1:0] out_blue;
    logic             out_of_store;
  } out_item_t;

  // classified queue entry
  typedef struct packed {
    logic             is_render;
    logic [IDX_W-1:0] load_addr;
    logic [PIX_W-1:0] pixel;
    logic [CRD_W-1:0] dst_x;
    logic [CRD_W-1:0] dst_y;
  } q_item_t;

  // geometry and colour settings seen by the render path
  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [SCL_W-1:0] scl_w;
    logic [SCL_W-1:0] scl_h;
    logic [SCL_W-1:0] crop_x;
    logic [SCL_W-1:0] crop_y;
    logic [COL_W-1:0] back_red;
    logic [COL_W-1:0] back_green;
    logic [COL_W-1:0] back_blue;
  } geom_t;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
                                                 input int unsigned mx);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (32'(v) > mx) r = DIM_W'(mx);
    return r;
  endfunction

  // exact floor(v / 255) for any 16-bit v below 65280, where the quotient fits in 8 bits
  function automatic logic [COL_W-1:0] div255(input logic [BL_W-1:0] v);
    logic [BL_W:0] t;
    t = (BL_W+1)'(v) + (BL_W+1)'(v >> COL_W) + (BL_W+1)'(1);
    return t[BL_W-1:COL_W];
  endfunction

endpackage

### src/afs_stream_if.sv
// valid/ready stream interface carrying one payload struct
interface afs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/aspect_fill_scaler_alpha_blend_core.sv
// top level of the aspect-fill scaler with alpha blend
// Scales a stored RGBA image to cover the screen by nearest-neighbour sampling
// and blends each rendered pixel over the background colour. Load and render
// requests are accepted at one per cycle while the geometry is valid and the
// queue is not full; a held output stalls the whole render path. A render
// result passes the queue, the multiply stage, the 14-stage pipelined dividers
// for the two axes, the clamp and index stages, the store read and the two
// blend stages. Loads give no result. After reset and after every
// configuration write the geometry unit recomputes the scaled size with a
// bit-serial divider, during which no request is accepted. The source store is
// not cleared: a render that samples a never-loaded entry returns an arbitrary
// colour.
module aspect_fill_scaler_alpha_blend_core #(
  parameter int SOURCE_PIXELS = afs_pkg::DEF_SOURCE_PIXELS,
  parameter int MAX_DIM       = afs_pkg::DEF_MAX_DIM
) (
  input  logic                            clk,
  input  logic                            rst_n,
  afs_stream_if.sink                      in_if,
  afs_stream_if.source                    out_if,
  input  logic                            cfg_we,
  input  logic [afs_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import afs_pkg::*;

  geom_t     geom;
  logic      head_valid, pop, front_ready, back_valid;
  q_item_t   head;
  out_item_t back_data;

  // configuration and geometry
  afs_geom #(.MAX_DIM(MAX_DIM)) u_geom (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .geom(geom)
  );

  // intake and queue
  afs_front u_front (
    .clk(clk), .rst_n(rst_n), .geom_ok(geom.valid), .in_valid(in_if.valid),
    .in_data(in_if.data), .in_ready(front_ready), .pop(pop),
    .head_valid(head_valid), .head(head)
  );

  // render path
  afs_back #(.SOURCE_PIXELS(SOURCE_PIXELS)) u_back (
    .clk(clk), .rst_n(rst_n), .geom(geom), .head_valid(head_valid), .head(head),
    .pop(pop), .out_ready(out_if.ready), .out_valid(back_valid),
    .out_data(back_data)
  );

  assign in_if.ready = front_ready;
  assign out_if.valid = back_valid;
  assign out_if.data  = back_data;

`ifndef SYNTHESIS
  // no request is taken before the geometry is settled
  a_accept_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> geom.valid)
    else $error("request accepted while geometry is stale");

  // a sample outside the store carries the background colour
  a_oos_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.data.out_of_store) |->
      (out_if.data.out_red == geom.back_red &&
       out_if.data.out_green == geom.back_green &&
       out_if.data.out_blue == geom.back_blue))
    else $error("out-of-store result without background colour");

  // a configuration write invalidates the geometry
  a_cfg_invalidates: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !geom.valid)
    else $error("geometry still valid after configuration write");
`endif

endmodule

### src/afs_geom.sv
// configuration registers and sequential geometry unit
module afs_geom #(
  parameter int MAX_DIM = afs_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [afs_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [afs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output afs_pkg::geom_t                    geom
);
  import afs_pkg::*;

  typedef enum logic [4:0] {
    G_MUL  = 5'b00001,
    G_CMP  = 5'b00010,
    G_DIV  = 5'b00100,
    G_FIN  = 5'b01000,
    G_DONE = 5'b10000
  } gstate_t;

  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [COL_W-1:0] back_red_r, back_green_r, back_blue_r;
  gstate_t          state_r;
  logic [DIM_W-1:0] sw_r, sh_r, dw_r, dh_r;
  logic [SCL_W-1:0] p1_r, p2_r;
  logic             wide_r;
  logic [GN_W-1:0]  num_r, quo_r;
  logic [GD_W-1:0]  den_r, rem_r;
  logic [GC_W-1:0]  cnt_r;
  logic [SCL_W-1:0] scl_w_r, scl_h_r, crop_x_r, crop_y_r;

  logic [DIM_W-1:0] csw, csh, cdw, cdh;
  logic [GD_W:0]    rem_sh;
  logic             ge;
  logic [GD_W-1:0]  rem_nxt;
  logic [GN_W-1:0]  quo_nxt;
  logic [SCL_W-1:0] q_min1, fin_w, fin_h, fin_cx, fin_cy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r      <= RST_SRC_WIDTH;
      src_h_r      <= RST_SRC_HEIGHT;
      dst_w_r      <= RST_DST_WIDTH;
      dst_h_r      <= RST_DST_HEIGHT;
      back_red_r   <= RST_BACK_RED;
      back_green_r <= RST_BACK_GREEN;
      back_blue_r  <= RST_BACK_BLUE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r      <= cfg_wdata;
        REG_SRC_HEIGHT: src_h_r      <= cfg_wdata;
        REG_DST_WIDTH:  dst_w_r      <= cfg_wdata;
        REG_DST_HEIGHT: dst_h_r      <= cfg_wdata;
        REG_BACK_RED:   back_red_r   <= cfg_wdata[COL_W-1:0];
        REG_BACK_GREEN: back_green_r <= cfg_wdata[COL_W-1:0];
        REG_BACK_BLUE:  back_blue_r  <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped dimensions
  always_comb begin
    csw = dim_clamp(src_w_r, MAX_DIM);
    csh = dim_clamp(src_h_r, MAX_DIM);
    cdw = dim_clamp(dst_w_r, MAX_DIM);
    cdh = dim_clamp(dst_h_r, MAX_DIM);
  end

  // one restoring division step per cycle
  always_comb begin
    rem_sh  = {rem_r, num_r[GN_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? GD_W'(rem_sh - {1'b0, den_r}) : rem_sh[GD_W-1:0];
    quo_nxt = {quo_r[GN_W-2:0], ge};
  end

  // final scaled size and crop offsets
  always_comb begin
    q_min1 = (quo_r[SCL_W-1:0] == '0) ? SCL_W'(1) : quo_r[SCL_W-1:0];
    fin_w  = wide_r ? SCL_W'(dw_r) : q_min1;
    fin_h  = wide_r ? q_min1 : SCL_W'(dh_r);
    fin_cx = (fin_w >= SCL_W'(dw_r)) ? ((fin_w - SCL_W'(dw_r)) >> 1) : '0;
    fin_cy = (fin_h >= SCL_W'(dh_r)) ? ((fin_h - SCL_W'(dh_r)) >> 1) : '0;
  end

  // geometry sequencer, restarted by every configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= G_MUL;
      scl_w_r  <= '0;
      scl_h_r  <= '0;
      crop_x_r <= '0;
      crop_y_r <= '0;
    end else if (cfg_we) begin
      state_r <= G_MUL;
    end else begin
      case (state_r)
        G_MUL: begin
          sw_r    <= csw;
          sh_r    <= csh;
          dw_r    <= cdw;
          dh_r    <= cdh;
          p1_r    <= SCL_W'(cdw) * SCL_W'(csh);
          p2_r    <= SCL_W'(cdh) * SCL_W'(csw);
          state_r <= G_CMP;
        end
        G_CMP: begin
          wide_r <= p1_r >= p2_r;
          if (p1_r >= p2_r) begin
            num_r <= GN_W'({p1_r, 1'b0}) + GN_W'(sw_r);
            den_r <= {sw_r, 1'b0};
          end else begin
            num_r <= GN_W'({p2_r, 1'b0}) + GN_W'(sh_r);
            den_r <= {sh_r, 1'b0};
          end
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= GC_W'(GN_W - 1);
          state_r <= G_DIV;
        end
        G_DIV: begin
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          num_r <= {num_r[GN_W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= G_FIN;
        end
        G_FIN: begin
          scl_w_r  <= fin_w;
          scl_h_r  <= fin_h;
          crop_x_r <= fin_cx;
          crop_y_r <= fin_cy;
          state_r  <= G_DONE;
        end
        G_DONE: ;
        default: state_r <= G_MUL;
      endcase
    end
  end

  always_comb begin
    geom.valid      = (state_r == G_DONE);
    geom.sw         = sw_r;
    geom.sh         = sh_r;
    geom.scl_w      = scl_w_r;
    geom.scl_h      = scl_h_r;
    geom.crop_x     = crop_x_r;
    geom.crop_y     = crop_y_r;
    geom.back_red   = back_red_r;
    geom.back_green = back_green_r;
    geom.back_blue  = back_blue_r;
  end

endmodule

### src/afs_front.sv
// request intake: classifies requests and queues them for the render path
module afs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              geom_ok,
  input  logic              in_valid,
  input  afs_pkg::in_item_t in_data,
  output logic              in_ready,
  input  logic              pop,
  output logic              head_valid,
  output afs_pkg::q_item_t  head
);
  import afs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  q_item_t          mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, do_pop;
  q_item_t          entry;

  // classify the incoming request
  always_comb begin
    entry.is_render = (in_data.func == FUNC_RENDER);
    entry.load_addr = in_data.src_index;
    entry.pixel     = {in_data.pix_alpha, in_data.pix_blue, in_data.pix_green,
                       in_data.pix_red};
    entry.dst_x     = in_data.dst_x;
    entry.dst_y     = in_data.dst_y;
  end

  // handshake and queue head
  always_comb begin
    in_ready   = geom_ok && (cnt_r != CNT_W'(FIFO_DEPTH));
    push       = in_valid && in_ready;
    head_valid = (cnt_r != '0);
    do_pop     = pop && head_valid;
    head       = mem_r[rd_ptr_r];
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= entry;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### src/afs_pdiv.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module afs_pdiv (
  input  logic                        clk,
  input  logic                        en,
  input  logic [afs_pkg::NUM_W-1:0]   num,
  input  logic [afs_pkg::SCL_W-1:0]   den,
  output logic [afs_pkg::Q_W-1:0]     quo
);
  import afs_pkg::*;

  logic [NUM_W-1:0] rem_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             ovf_r [Q_W+1];

  // first stage: load the dividend and flag a quotient too big for the result width
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      ovf_r[0] <= num >= (NUM_W'(den) << Q_W);
    end
  end

  // one bit per stage, most significant first
  for (genvar i = 1; i <= Q_W; i++) begin : g_stage
    localparam int B = Q_W - i;
    logic [NUM_W-1:0] dsh;
    logic             ge;
    always_comb begin
      dsh = NUM_W'(den) << B;
      ge  = rem_r[i-1] >= dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_r[i-1] - dsh : rem_r[i-1];
        q_r[i]   <= ge ? (q_r[i-1] | (Q_W'(1) << B)) : q_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign quo = ovf_r[Q_W] ? '1 : q_r[Q_W];

endmodule

### src/afs_back.sv
// render path: sampling, source store access and alpha blend
module afs_back #(
  parameter int SOURCE_PIXELS = afs_pkg::DEF_SOURCE_PIXELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  afs_pkg::geom_t     geom,
  input  logic               head_valid,
  input  afs_pkg::q_item_t   head,
  output logic               pop,
  input  logic               out_ready,
  output logic               out_valid,
  output afs_pkg::out_item_t out_data
);
  import afs_pkg::*;

  localparam int AW = $clog2(SOURCE_PIXELS);

  logic             en;
  logic             s1_v_r;
  q_item_t          s1_item_r;
  logic [NUM_W-1:0] nx_r, ny_r;
  logic             sc_v_r    [DIV_LAT];
  q_item_t          sc_item_r [DIV_LAT];
  logic [Q_W-1:0]   qx, qy;
  logic             c_v_r;
  q_item_t          c_item_r;
  logic [DIM_W-1:0] sx_r, sy_r;
  logic             d_v_r, d_oos_r, d_ld_ok_r;
  q_item_t          d_item_r;
  logic [LIN_W-1:0] idx_r, idx_nxt;
  logic [PIX_W-1:0] store_mem [SOURCE_PIXELS];
  logic [PIX_W-1:0] rd_r;
  logic             e_v_r, e_oos_r;
  logic             f_v_r, f_oos_r;
  logic [BL_W-1:0]  f_red_r, f_green_r, f_blue_r;
  logic [COL_W-1:0] alpha, inv_alpha;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // the whole path moves when the output register is free or taken
  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_valid;

  // stage 1: scaled-plane coordinate times source size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= head;
      nx_r <= NUM_W'(SUM_W'(head.dst_x) + SUM_W'(geom.crop_x)) * NUM_W'(geom.sw);
      ny_r <= NUM_W'(SUM_W'(head.dst_y) + SUM_W'(geom.crop_y)) * NUM_W'(geom.sh);
    end
  end

  // dividers by the scaled size
  afs_pdiv u_div_x (.clk(clk), .en(en), .num(nx_r), .den(geom.scl_w), .quo(qx));
  afs_pdiv u_div_y (.clk(clk), .en(en), .num(ny_r), .den(geom.scl_h), .quo(qy));

  // request sideband alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) sc_v_r[i] <= 1'b0;
    end else if (en) begin
      sc_v_r[0] <= s1_v_r;
      for (int i = 1; i < DIV_LAT; i++) sc_v_r[i] <= sc_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_item_r[0] <= s1_item_r;
      for (int i = 1; i < DIV_LAT; i++) sc_item_r[i] <= sc_item_r[i-1];
    end
  end

  // clamp source coordinates to the image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= sc_v_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_item_r <= sc_item_r[DIV_LAT-1];
      sx_r     <= (qx >= geom.sw) ? geom.sw - 1'b1 : qx;
      sy_r     <= (qy >= geom.sh) ? geom.sh - 1'b1 : qy;
    end
  end

  // row-major index and range checks
  assign idx_nxt = LIN_W'(sy_r) * LIN_W'(geom.sw) + LIN_W'(sx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_item_r  <= c_item_r;
      idx_r     <= idx_nxt;
      d_oos_r   <= 32'(idx_nxt) >= 32'(SOURCE_PIXELS);
      d_ld_ok_r <= 32'(c_item_r.load_addr) < 32'(SOURCE_PIXELS);
    end
  end

  // source store: a load writes, a render reads
  always_ff @(posedge clk) begin
    if (en && d_v_r) begin
      if (!d_item_r.is_render) begin
        if (d_ld_ok_r) store_mem[AW'(d_item_r.load_addr)] <= d_item_r.pixel;
      end else begin
        rd_r <= store_mem[AW'(idx_r)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r && d_item_r.is_render;
    end
  end

  always_ff @(posedge clk) begin
    if (en) e_oos_r <= d_oos_r;
  end

  // blend products
  assign alpha     = rd_r[PIX_W-1 -: COL_W];
  assign inv_alpha = ALPHA_OPAQUE - alpha;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_oos_r   <= e_oos_r;
      f_red_r   <= BL_W'(rd_r[COL_W-1:0]) * BL_W'(alpha)
                 + BL_W'(geom.back_red) * BL_W'(inv_alpha);
      f_green_r <= BL_W'(rd_r[2*COL_W-1 -: COL_W]) * BL_W'(alpha)
                 + BL_W'(geom.back_green) * BL_W'(inv_alpha);
      f_blue_r  <= BL_W'(rd_r[3*COL_W-1 -: COL_W]) * BL_W'(alpha)
                 + BL_W'(geom.back_blue) * BL_W'(inv_alpha);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.out_of_store <= f_oos_r;
      out_data_r.out_red      <= f_oos_r ? geom.back_red   : div255(f_red_r);
      out_data_r.out_green    <= f_oos_r ? geom.back_green : div255(f_green_r);
      out_data_r.out_blue     <= f_oos_r ? geom.back_blue  : div255(f_blue_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
